// File: src/sla_pkg.sv
// shared constants and control/status types for the serial line assembler
package sla_pkg;

  // line store geometry
  localparam int LINE_CAPACITY = 64;
  localparam int STORE_DEPTH   = 64;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  // count never exceeds the line limit, which stays below the store depth
  localparam int CNT_W         = ADDR_W;
  localparam int DATA_W        = 7;
  localparam int BYTE_W        = 8;

  localparam logic [CNT_W-1:0] LINE_LIMIT = CNT_W'(LINE_CAPACITY - 3);

  // character codes
  localparam logic [BYTE_W-1:0] CHAR_NUL = 8'd0;
  localparam logic [BYTE_W-1:0] CHAR_LF  = 8'd10;
  localparam logic [BYTE_W-1:0] CHAR_CR  = 8'd13;
  localparam logic [BYTE_W-1:0] PRINT_LO = 8'd32;
  localparam logic [BYTE_W-1:0] PRINT_HI = 8'd126;

  // commands from the controller
  typedef struct packed {
    logic store;    // write word into the store, bump count
    logic rd_en;    // read store at read index
    logic ld_data;  // load read data into output register, bump index
    logic ld_lf;    // load line feed into output register
    logic ld_cr;    // load closing carriage return, clear count and index
  } sla_cmd_t;

  // status back to the controller
  typedef struct packed {
    logic is_print;
    logic is_end;
    logic idx_done;
    logic out_free;
  } sla_sts_t;

endpackage

// File: src/sla_ram.sv
// generic single write port, single read port ram with registered read
module sla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/sla_ctrl.sv
// controller state machine for the serial line assembler
module sla_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sla_pkg::sla_sts_t sts_i,
  output sla_pkg::sla_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_LF   = 3'd3;
  localparam logic [2:0] S_CR   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.store = sts_i.is_print;
          if (sts_i.is_end) begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        if (sts_i.idx_done) begin
          state_d = S_LF;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_LOAD;
        end
      end
      S_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.ld_data = 1'b1;
          state_d       = S_READ;
        end
      end
      S_LF: begin
        if (sts_i.out_free) begin
          cmd_o.ld_lf = 1'b1;
          state_d     = S_CR;
        end
      end
      S_CR: begin
        if (sts_i.out_free) begin
          cmd_o.ld_cr = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: src/sla_dp.sv
// datapath: byte decode, line store, count, read index and output register
module sla_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [sla_pkg::BYTE_W-1:0]    rx_byte_i,
  input  sla_pkg::sla_cmd_t             cmd_i,
  output sla_pkg::sla_sts_t             sts_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sla_pkg::BYTE_W-1:0]    out_byte_o,
  output logic                          last_of_line_o
);

  logic [sla_pkg::CNT_W-1:0]  count_q, count_d;
  logic [sla_pkg::ADDR_W-1:0] idx_q, idx_d;
  logic [sla_pkg::DATA_W-1:0] rdata;
  logic [sla_pkg::CNT_W:0]    count_inc;
  logic                       is_print;
  logic                       out_valid_q, out_valid_d;
  logic [sla_pkg::BYTE_W-1:0] out_byte_q, out_byte_d;
  logic                       out_last_q, out_last_d;
  logic                       out_free;

  assign is_print  = rx_byte_i inside {[sla_pkg::PRINT_LO:sla_pkg::PRINT_HI]};
  assign count_inc = {1'b0, count_q} + 1'b1;
  assign out_free  = !out_valid_q || !out_stall_i;

  assign sts_o.is_print = is_print;
  // line ends on cr or nul, or when the stored word fills the line
  assign sts_o.is_end   = (rx_byte_i == sla_pkg::CHAR_CR) ||
                          (rx_byte_i == sla_pkg::CHAR_NUL) ||
                          (is_print && (count_inc >= {1'b0, sla_pkg::LINE_LIMIT}));
  assign sts_o.idx_done = (idx_q == count_q);
  assign sts_o.out_free = out_free;

  sla_ram #(
    .WIDTH(sla_pkg::DATA_W),
    .DEPTH(sla_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.store),
    .waddr_i(count_q),
    .wdata_i(rx_byte_i[sla_pkg::DATA_W-1:0]),
    .re_i   (cmd_i.rd_en),
    .raddr_i(idx_q),
    .rdata_o(rdata)
  );

  always_comb begin
    count_d = count_q;
    idx_d   = idx_q;
    if (cmd_i.ld_cr) begin
      count_d = '0;
      idx_d   = '0;
    end else begin
      if (cmd_i.store) begin
        count_d = count_inc[sla_pkg::CNT_W-1:0];
      end
      if (cmd_i.ld_data) begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (cmd_i.ld_data) begin
      out_valid_d = 1'b1;
      out_byte_d  = {1'b0, rdata};
      out_last_d  = 1'b0;
    end else if (cmd_i.ld_lf) begin
      out_valid_d = 1'b1;
      out_byte_d  = sla_pkg::CHAR_LF;
      out_last_d  = 1'b0;
    end else if (cmd_i.ld_cr) begin
      out_valid_d = 1'b1;
      out_byte_d  = sla_pkg::CHAR_CR;
      out_last_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign last_of_line_o = out_last_q;

`ifndef SYNTHESIS
  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.ld_data || cmd_i.ld_lf || cmd_i.ld_cr) |-> out_free)
    else $error("output register loaded while holding an untaken word");

  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.ld_data, cmd_i.ld_lf, cmd_i.ld_cr}))
    else $error("more than one output load in a cycle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sla_pkg::LINE_LIMIT)
    else $error("line count beyond line limit");

  a_store_not_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store |-> (idx_q == '0))
    else $error("store write while a line is being flushed");

  a_cr_closes_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ld_cr |=> (out_valid_o && last_of_line_o && count_q == '0))
    else $error("closing carriage return not presented or count not cleared");
`endif

endmodule

// File: src/serial_line_assembler.sv
// top level of the serial line assembler: controller plus datapath
//
// Collects received words into a text line and replays the line on the
// output side. Printable words (32..126) go into a 64-entry line store;
// carriage return or nul ends the line, and so does the stored count
// reaching LINE_CAPACITY - 3. At the end of a line every stored word comes
// out in order, then line feed, then carriage return with last_of_line_o
// set, and the count clears; other control words are dropped silently.
// A word that does not end a line is taken without raising in_stall_o. A
// word that ends a line holds in_stall_o high while the line is flushed:
// each stored word is first read from the store, a registered read, and
// then loaded into the output register; line feed and carriage return
// follow. Output stalls lengthen the flush. Input stays stalled through
// the flush, so one line is handled at a time.
module serial_line_assembler (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [sla_pkg::BYTE_W-1:0] rx_byte_i,
  // output channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [sla_pkg::BYTE_W-1:0] out_byte_o,
  output logic                       last_of_line_o
);

  // command and status between controller and datapath
  sla_pkg::sla_cmd_t cmd;
  sla_pkg::sla_sts_t sts;

  // sequencing: accept, flush reads, line feed, closing carriage return
  sla_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // decode, line store, count and output register
  sla_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_byte_i     (rx_byte_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_line_o(last_of_line_o)
  );

endmodule

// File: bench/serial_line_assembler_tb.sv
// testbench for the serial line assembler: random line traffic checked against a line predictor
module serial_line_assembler_tb;

  // run limits: worst case is every word flushing a full line under long output stalls
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int ITEM_TARGET  = 350;
  localparam int TAIL_ITEMS   = 60;   // last stretch of the run, no idling on either side
  localparam int HOLD_AT      = 180;  // accepted words before the long output hold-off
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 200;  // quiet stretch after the last expected word, for stray output

  // one pending word for the sender, or a marker to wait for all output
  typedef struct {
    logic [sla_pkg::BYTE_W-1:0] val;
    bit                         pause;
  } rx_item_t;

  // one expected output word
  typedef struct {
    logic [sla_pkg::BYTE_W-1:0] data;
    logic                       last;
  } line_word_t;

  logic                       clk_i          = 1'b0;
  logic                       rst_ni         = 1'b0;
  logic                       in_valid_i     = 1'b0;
  logic                       in_stall_o;
  logic [sla_pkg::BYTE_W-1:0] rx_byte_i      = '0;
  logic                       out_valid_o;
  logic                       out_stall_i    = 1'b0;
  logic [sla_pkg::BYTE_W-1:0] out_byte_o;
  logic                       last_of_line_o;

  serial_line_assembler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .last_of_line_o (last_of_line_o)
  );

  // stimulus and expectations
  rx_item_t   rx_pending[$];
  line_word_t line_expect[$];

  // shadow copy of the line store and its fill count
  logic [sla_pkg::DATA_W-1:0] line_shadow [sla_pkg::STORE_DEPTH];
  logic [sla_pkg::CNT_W-1:0]  line_fill = '0;

  // handshake bookkeeping shared between the clocked processes
  bit rx_took      = 1'b0;  // input word accepted at the last rising edge
  int rx_accepted  = 0;
  bit hold_armed   = 1'b0;
  int mismatch_cnt = 0;
  int cycle_cnt    = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // line predictor: store printable words, flush the line on cr, nul or a full count
  function automatic void assemble_byte(logic [sla_pkg::BYTE_W-1:0] b);
    if (b >= sla_pkg::PRINT_LO && b <= sla_pkg::PRINT_HI) begin
      line_shadow[line_fill] = b[sla_pkg::DATA_W-1:0];
      line_fill++;
    end
    if (b == sla_pkg::CHAR_CR || b == sla_pkg::CHAR_NUL || line_fill >= sla_pkg::LINE_LIMIT) begin
      for (int k = 0; k < int'(line_fill); k++)
        line_expect.push_back('{data: sla_pkg::BYTE_W'(line_shadow[k]), last: 1'b0});
      line_expect.push_back('{data: sla_pkg::CHAR_LF, last: 1'b0});
      line_expect.push_back('{data: sla_pkg::CHAR_CR, last: 1'b1});
      line_fill = '0;
    end
  endfunction

  function automatic void flag_mismatch(string what, int want, int got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endfunction

  function automatic void push_byte(logic [sla_pkg::BYTE_W-1:0] b);
    rx_pending.push_back('{val: b, pause: 1'b0});
  endfunction

  function automatic void push_pause();
    rx_pending.push_back('{val: '0, pause: 1'b1});
  endfunction

  // control word that is neither printable nor a line end, dropped by the block
  function automatic logic [sla_pkg::BYTE_W-1:0] noise_byte();
    logic [sla_pkg::BYTE_W-1:0] b;
    if ($urandom_range(0, 1) == 0) begin
      do b = sla_pkg::BYTE_W'($urandom_range(1, 31)); while (b == sla_pkg::CHAR_CR);
    end else begin
      b = sla_pkg::BYTE_W'($urandom_range(127, 255));
    end
    return b;
  endfunction

  // sender: new word only after the previous one was taken, with random idle bursts
  always @(negedge clk_i) begin : drive_rx
    rx_item_t nxt;
    int       gap_left;
    if (rst_ni && (!in_valid_i || rx_took)) begin
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left--;
      end else if (rx_pending.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (rx_pending[0].pause) begin
        // hold off until every expected word has come out
        in_valid_i <= 1'b0;
        if (line_expect.size() == 0)
          void'(rx_pending.pop_front());
      end else if (rx_pending.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
        in_valid_i <= 1'b0;
        gap_left = $urandom_range(0, 11);
      end else begin
        nxt = rx_pending.pop_front();
        in_valid_i <= 1'b1;
        rx_byte_i  <= nxt.val;
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off that backs up the input side
  always @(negedge clk_i) begin : drive_stall
    int hold_left;
    int gap_left;
    if (rst_ni) begin
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (hold_armed) begin
        hold_armed = 1'b0;
        hold_left  = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else if (gap_left > 0) begin
        out_stall_i <= 1'b1;
        gap_left--;
      end else if (rx_pending.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        gap_left = $urandom_range(0, 11);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // monitor: predict on accepted input words, check accepted output words in order
  always @(posedge clk_i) begin : monitor
    line_word_t want;
    rx_took = rst_ni && in_valid_i && !in_stall_o;
    if (rx_took) begin
      assemble_byte(rx_byte_i);
      rx_accepted++;
      if (rx_accepted == HOLD_AT)
        hold_armed = 1'b1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (line_expect.size() == 0) begin
        flag_mismatch("unexpected out_byte", -1, int'(out_byte_o));
      end else begin
        want = line_expect.pop_front();
        if (out_byte_o !== want.data)
          flag_mismatch("out_byte", int'(want.data), int'(out_byte_o));
        if (last_of_line_o !== want.last)
          flag_mismatch("last_of_line", int'(want.last), int'(last_of_line_o));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL serial_line_assembler");
      $finish;
    end
  end

  initial begin : main
    int counted;
    int line_no;
    int pick;
    int len;
    logic [sla_pkg::BYTE_W-1:0] b;

    // directed: empty lines on nul and cr, printable extremes, dropped control words
    push_byte(sla_pkg::CHAR_NUL);
    push_byte(sla_pkg::CHAR_CR);
    push_byte(sla_pkg::PRINT_LO);
    push_byte(sla_pkg::PRINT_HI);
    push_byte(8'd31);
    push_byte(8'd127);
    push_byte(8'd255);
    push_byte(8'd128);
    push_byte(8'd1);
    push_byte(sla_pkg::CHAR_LF);
    push_byte(8'd65);
    push_byte(sla_pkg::CHAR_CR);
    push_byte(8'd122);
    push_byte(8'd48);
    push_byte(sla_pkg::CHAR_NUL);
    push_pause();

    // random lines: mostly short, some long enough to end on a full count
    counted = 0;
    line_no = 0;
    while (counted < ITEM_TARGET) begin
      if (line_no == 6)
        push_pause();
      pick = $urandom_range(0, 9);
      if (pick == 9 && line_no != 0) begin
        // raw noise from the whole byte range
        repeat ($urandom_range(1, 4)) begin
          b = sla_pkg::BYTE_W'($urandom_range(0, 255));
          push_byte(b);
          if ((b >= sla_pkg::PRINT_LO && b <= sla_pkg::PRINT_HI) ||
              b == sla_pkg::CHAR_CR || b == sla_pkg::CHAR_NUL)
            counted++;
        end
      end else begin
        len = (line_no == 0 || pick == 0) ? $urandom_range(58, 66) : $urandom_range(0, 12);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 9) == 0)
            push_byte(noise_byte());
          push_byte(sla_pkg::BYTE_W'($urandom_range(32, 126)));
          counted++;
        end
        push_byte($urandom_range(0, 1) ? sla_pkg::CHAR_CR : sla_pkg::CHAR_NUL);
        counted++;
      end
      line_no++;
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // all words sent, then all lines flushed, then a quiet stretch for stray output
    do @(posedge clk_i); while (rx_pending.size() != 0 || in_valid_i);
    while (line_expect.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0 && line_expect.size() == 0) begin
      $display("PASS serial_line_assembler");
    end else begin
      $display("FAIL serial_line_assembler");
    end
    $finish;
  end

endmodule
